// ----- design/bpgs_pkg.sv -----
// ----------------------------------------------------------------------------
// Burst prediction scheduler package
// Shared command codes, datapath operations and controller status types.
// ----------------------------------------------------------------------------
package bpgs_pkg;

   // Width of the goodness arithmetic (integer wrap of the products).
   localparam int GOOD_BITS = 64;
   localparam int HALF_BITS = 32;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_WAKE   = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_SCHED  = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LATCH,
      OP_ADD,
      OP_RD_SLOT,
      OP_WAKE,
      OP_REMOVE,
      OP_SEED,
      OP_RD_CUR,
      OP_ACC,
      OP_PRED1,
      OP_PRED2,
      OP_WR_CUR,
      OP_WALK_INIT,
      OP_RD_IDX,
      OP_WAIT_UPD,
      OP_G_INIT,
      OP_DIV1,
      OP_DIV2,
      OP_Q2,
      OP_M0,
      OP_M1,
      OP_M2,
      OP_G_CMP,
      OP_IDX_INC,
      OP_F_RUN,
      OP_F_FIN
   } op_type;

   typedef struct packed {
      cmd_type cmd;
      logic    slot_ok;
      logic    slot_present;
      logic    count_le1;
      logic    cur_zero;
      logic    cur_valid;
      logic    idx_valid;
      logic    idx_last;
      logic    div_done;
   } status_type;

endpackage

// ----- design/bpgs_div.sv -----
// ----------------------------------------------------------------------------
// Serial dividers
// Restoring unsigned divider, one quotient bit per cycle. A zero divisor
// yields an all-ones quotient. A divide-by-three unit built from shifts and
// adds follows.
// ----------------------------------------------------------------------------
module bpgs_div #(
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DW + 1);

   logic [DW:0]         rem_ff;
   logic [DW-1:0]       quo_ff;
   logic [DW-1:0]       dvs_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                run_ff;
   logic                done_ff;
   logic [DW:0]         shifted;
   logic [DW:0]         diff;
   logic                take;

   always_comb begin
      shifted = {rem_ff[DW-1:0], quo_ff[DW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      take    = (shifted >= {1'b0, dvs_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            quo_ff <= dividend;
            dvs_ff <= divisor;
            cnt_ff <= CNT_BITS'(DW);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= take ? diff : shifted;
            quo_ff <= {quo_ff[DW-2:0], take};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// Division by three. The estimate x/4 + x/16 is widened by the series
// q += q>>4, q>>8, q>>16, q>>32, one add per cycle, and the small remainder
// left over (always below 32) is folded in through 11*r/32. DW is at least 64.
module bpgs_div3 #(
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   output logic          done,
   output logic [DW-1:0] quotient
);

   logic [DW-1:0] x_ff;
   logic [DW-1:0] q_ff;
   logic [2:0]    step_ff;
   logic          run_ff;
   logic          done_ff;
   logic [DW-1:0] rem;
   logic [11:0]   corr;
   logic [DW-1:0] q_add;

   always_comb begin
      rem  = x_ff - ((q_ff << 1) + q_ff);
      corr = ({4'd0, rem[7:0]} << 3) + ({4'd0, rem[7:0]} << 1) + {4'd0, rem[7:0]};
      case (step_ff)
         3'd0:    q_add = q_ff >> 4;
         3'd1:    q_add = q_ff >> 8;
         3'd2:    q_add = q_ff >> 16;
         3'd3:    q_add = q_ff >> 32;
         default: q_add = DW'(corr[11:5]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff    <= dividend;
            q_ff    <= (dividend >> 2) + (dividend >> 4);
            step_ff <= '0;
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            q_ff    <= q_ff + q_add;
            step_ff <= step_ff + 1'b1;
            if (step_ff == 3'd4) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- design/bpgs_datapath.sv -----
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task table memories, valid bits, walk registers, shared divider, a
// divide-by-three unit and shared 32x32 multiplier, driven one operation
// per cycle.
// ----------------------------------------------------------------------------
module bpgs_datapath #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 48,
   parameter int DW        = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bpgs_pkg::op_type      op,
   input  logic [1:0]            req_cmd,
   input  logic [3:0]            req_task_slot,
   input  logic [TIME_BITS-1:0]  req_now,
   output bpgs_pkg::status_type  status,
   output logic                  rsp_valid,
   output logic [3:0]            rsp_next_task
);

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int GW = bpgs_pkg::GOOD_BITS;
   localparam int HW = bpgs_pkg::HALF_BITS;
   localparam int TB = TIME_BITS;

   logic [TB-1:0] pred_mem   [NUM_SLOTS];
   logic [TB-1:0] accum_mem  [NUM_SLOTS];
   logic [TB-1:0] queued_mem [NUM_SLOTS];
   logic [TB-1:0] runst_mem  [NUM_SLOTS];
   logic [TB-1:0] wait_mem   [NUM_SLOTS];

   bpgs_pkg::cmd_type cmd_ff;
   logic [3:0]           slot_ff;
   logic [TB-1:0]        now_ff;
   logic [IW-1:0]        idx_ff;
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [CW-1:0]        count_ff;
   logic [IW-1:0]        cur_ff;
   logic [IW-1:0]        next_ff;
   logic [TB-1:0]        accum_ff;
   logic [TB-1:0]        pred_ff;
   logic [TB-1:0]        saved_ff;
   logic [TB-1:0]        minpred_ff;
   logic [TB-1:0]        maxwait_ff;
   logic                 have_min_ff;
   logic [GW-1:0]        q1_ff;
   logic [GW-1:0]        q2_ff;
   logic [GW-1:0]        prod_ff;
   logic [GW-1:0]        best_ff;
   logic [TB-1:0]        rd_pred_ff;
   logic [TB-1:0]        rd_accum_ff;
   logic [TB-1:0]        rd_queued_ff;
   logic [TB-1:0]        rd_runst_ff;
   logic [TB-1:0]        rd_wait_ff;
   logic                 rsp_valid_ff;
   logic [3:0]           rsp_task_ff;

   logic [IW-1:0] slot_idx;
   logic [IW-1:0] wa;
   logic [IW-1:0] ra;
   logic          re;
   logic          we_pred, we_accum, we_queued, we_runst, we_wait;
   logic [TB-1:0] wd_pred, wd_accum, wd_queued, wd_runst, wd_wait;
   logic [TB-1:0] accum_new;
   logic [TB-1:0] wait_new;
   logic          div_start;
   logic [DW-1:0] div_num;
   logic [DW-1:0] div_den;
   logic          div_done;
   logic [DW-1:0] div_quo;
   logic          d3_start;
   logic [DW-1:0] d3_num;
   logic          d3_done;
   logic [DW-1:0] d3_quo;
   logic [HW-1:0] mul_a;
   logic [HW-1:0] mul_b;
   logic [GW-1:0] mul_p;

   assign slot_idx  = IW'(slot_ff);
   assign accum_new = rd_accum_ff + (now_ff - rd_runst_ff);
   assign wait_new  = (idx_ff == cur_ff) ? '0 : (now_ff - rd_queued_ff);
   assign mul_p     = GW'(mul_a) * GW'(mul_b);

   bpgs_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // The prediction floor((2*burst+pred)/3) goes through the divide-by-three unit.
   bpgs_div3 #(.DW(DW)) u_div3 (
      .clock    (clock),
      .reset    (reset),
      .start    (d3_start),
      .dividend (d3_num),
      .done     (d3_done),
      .quotient (d3_quo)
   );

   // Divider and multiplier operand selection.
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      d3_start  = 1'b0;
      d3_num    = '0;
      mul_a     = q1_ff[HW-1:0];
      mul_b     = q2_ff[HW-1:0];
      unique case (op)
         bpgs_pkg::OP_ACC: begin
            d3_start = 1'b1;
            d3_num   = DW'({accum_new, 1'b0}) + DW'(rd_pred_ff);
         end
         bpgs_pkg::OP_PRED1: begin
            d3_start = !valid_ff[cur_ff];
            d3_num   = DW'({accum_ff, 1'b0}) + DW'(d3_quo[TB-1:0]);
         end
         bpgs_pkg::OP_DIV1: begin
            div_start = 1'b1;
            div_num   = DW'(GW'(rd_pred_ff) + GW'(1));
            div_den   = DW'(GW'(minpred_ff) + GW'(1));
         end
         bpgs_pkg::OP_DIV2: begin
            div_start = 1'b1;
            div_num   = DW'(GW'(maxwait_ff) + GW'(1));
            div_den   = DW'(GW'(rd_wait_ff) + GW'(1));
         end
         bpgs_pkg::OP_M1: begin
            mul_b = q2_ff[GW-1:HW];
         end
         bpgs_pkg::OP_M2: begin
            mul_a = q1_ff[GW-1:HW];
         end
         default: ;
      endcase
   end

   // Memory port controls.
   always_comb begin
      re = 1'b0;
      ra = idx_ff;
      wa = idx_ff;
      {we_pred, we_accum, we_queued, we_runst, we_wait} = '0;
      wd_pred   = '0;
      wd_accum  = '0;
      wd_queued = '0;
      wd_runst  = '0;
      wd_wait   = '0;
      unique case (op)
         bpgs_pkg::OP_CLEAR: begin
            {we_pred, we_accum, we_queued, we_runst, we_wait} = '1;
         end
         bpgs_pkg::OP_ADD: begin
            wa = slot_idx;
            {we_pred, we_accum, we_queued, we_runst, we_wait} = '1;
            wd_queued = now_ff;
         end
         bpgs_pkg::OP_RD_SLOT: begin
            re = 1'b1;
            ra = slot_idx;
         end
         bpgs_pkg::OP_WAKE: begin
            wa        = slot_idx;
            we_queued = 1'b1;
            wd_queued = (now_ff > rd_queued_ff) ? now_ff : rd_queued_ff;
         end
         bpgs_pkg::OP_RD_CUR: begin
            re = 1'b1;
            ra = cur_ff;
         end
         bpgs_pkg::OP_WR_CUR: begin
            wa       = cur_ff;
            we_pred  = 1'b1;
            we_accum = 1'b1;
            wd_pred  = pred_ff;
            wd_accum = accum_ff;
         end
         bpgs_pkg::OP_RD_IDX: begin
            re = 1'b1;
         end
         bpgs_pkg::OP_WAIT_UPD: begin
            we_wait = valid_ff[idx_ff];
            wd_wait = wait_new;
         end
         bpgs_pkg::OP_F_RUN: begin
            re       = 1'b1;
            ra       = cur_ff;
            wa       = next_ff;
            we_runst = 1'b1;
            wd_runst = now_ff;
         end
         bpgs_pkg::OP_F_FIN: begin
            wa = cur_ff;
            if (next_ff != cur_ff) begin
               we_queued = (now_ff > rd_queued_ff);
               wd_queued = now_ff;
            end else begin
               we_pred = 1'b1;
               wd_pred = saved_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_pred)   pred_mem[wa]   <= wd_pred;
      if (we_accum)  accum_mem[wa]  <= wd_accum;
      if (we_queued) queued_mem[wa] <= wd_queued;
      if (we_runst)  runst_mem[wa]  <= wd_runst;
      if (we_wait)   wait_mem[wa]   <= wd_wait;
      if (re) begin
         rd_pred_ff   <= pred_mem[ra];
         rd_accum_ff  <= accum_mem[ra];
         rd_queued_ff <= queued_mem[ra];
         rd_runst_ff  <= runst_mem[ra];
         rd_wait_ff   <= wait_mem[ra];
      end
   end

   // Control state of the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         valid_ff     <= NUM_SLOTS'(1);
         count_ff     <= CW'(1);
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (op)
            bpgs_pkg::OP_CLEAR,
            bpgs_pkg::OP_WAIT_UPD,
            bpgs_pkg::OP_IDX_INC: begin
               idx_ff <= idx_ff + 1'b1;
            end
            bpgs_pkg::OP_ADD,
            bpgs_pkg::OP_WAKE: begin
               valid_ff[slot_idx] <= 1'b1;
               count_ff           <= count_ff + 1'b1;
            end
            bpgs_pkg::OP_REMOVE: begin
               valid_ff[slot_idx] <= 1'b0;
               count_ff           <= count_ff - 1'b1;
            end
            bpgs_pkg::OP_SEED: begin
               cur_ff       <= '0;
               rsp_valid_ff <= 1'b1;
            end
            bpgs_pkg::OP_WR_CUR,
            bpgs_pkg::OP_WALK_INIT,
            bpgs_pkg::OP_G_INIT: begin
               idx_ff <= IW'(1);
            end
            bpgs_pkg::OP_G_CMP: begin
               idx_ff <= idx_ff + 1'b1;
            end
            bpgs_pkg::OP_F_FIN: begin
               cur_ff       <= next_ff;
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Payload registers of the schedule walk.
   always_ff @(posedge clock) begin
      unique case (op)
         bpgs_pkg::OP_LATCH: begin
            cmd_ff  <= bpgs_pkg::cmd_type'(req_cmd);
            slot_ff <= req_task_slot;
            now_ff  <= req_now;
         end
         bpgs_pkg::OP_SEED: begin
            rsp_task_ff <= '0;
         end
         bpgs_pkg::OP_ACC: begin
            accum_ff <= accum_new;
            saved_ff <= rd_pred_ff;
         end
         bpgs_pkg::OP_PRED1: begin
            pred_ff <= d3_quo[TB-1:0];
         end
         bpgs_pkg::OP_PRED2: begin
            pred_ff  <= d3_quo[TB-1:0];
            accum_ff <= '0;
         end
         bpgs_pkg::OP_WR_CUR,
         bpgs_pkg::OP_WALK_INIT: begin
            have_min_ff <= 1'b0;
            maxwait_ff  <= '0;
         end
         bpgs_pkg::OP_WAIT_UPD: begin
            if (valid_ff[idx_ff]) begin
               if (!have_min_ff || rd_pred_ff < minpred_ff) minpred_ff <= rd_pred_ff;
               have_min_ff <= 1'b1;
               if (wait_new >= maxwait_ff) maxwait_ff <= wait_new;
            end
         end
         bpgs_pkg::OP_G_INIT: begin
            best_ff <= '1;
            next_ff <= '0;
         end
         bpgs_pkg::OP_DIV2: begin
            q1_ff <= div_quo[GW-1:0];
         end
         bpgs_pkg::OP_Q2: begin
            q2_ff <= div_quo[GW-1:0];
         end
         bpgs_pkg::OP_M0: begin
            prod_ff <= mul_p;
         end
         bpgs_pkg::OP_M1,
         bpgs_pkg::OP_M2: begin
            prod_ff <= prod_ff + {mul_p[HW-1:0], {HW{1'b0}}};
         end
         bpgs_pkg::OP_G_CMP: begin
            if (prod_ff <= best_ff) begin
               best_ff <= prod_ff;
               next_ff <= idx_ff;
            end
         end
         bpgs_pkg::OP_F_FIN: begin
            rsp_task_ff <= 4'(next_ff);
         end
         default: ;
      endcase
   end

   always_comb begin
      status.cmd          = cmd_ff;
      status.slot_ok      = (slot_ff != '0) && (int'(slot_ff) < NUM_SLOTS);
      status.slot_present = valid_ff[slot_idx];
      status.count_le1    = (count_ff <= CW'(1));
      status.cur_zero     = (cur_ff == '0);
      status.cur_valid    = valid_ff[cur_ff];
      status.idx_valid    = valid_ff[idx_ff];
      status.idx_last     = (idx_ff == IW'(NUM_SLOTS - 1));
      status.div_done     = div_done || d3_done;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_task = rsp_task_ff;

endmodule

// ----- design/bpgs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences the clearing pass, table commands and the two schedule walks.
// ----------------------------------------------------------------------------
module bpgs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bpgs_pkg::status_type status,
   output bpgs_pkg::op_type     op,
   output logic                 busy
);

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_WAKE,
      ST_UPD1,
      ST_UPD1_WAIT,
      ST_UPD2_WAIT,
      ST_WR_CUR,
      ST_W_RD,
      ST_W_UPD,
      ST_G_INIT,
      ST_G_RD,
      ST_G_DIV1,
      ST_G_DIV1_WAIT,
      ST_G_DIV2_WAIT,
      ST_G_M0,
      ST_G_M1,
      ST_G_M2,
      ST_G_CMP,
      ST_F_RUN,
      ST_F_FIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      op       = bpgs_pkg::OP_NONE;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            op = bpgs_pkg::OP_CLEAR;
            if (status.idx_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               op       = bpgs_pkg::OP_LATCH;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            unique case (status.cmd)
               bpgs_pkg::CMD_ADD: begin
                  if (status.slot_ok && !status.slot_present) op = bpgs_pkg::OP_ADD;
               end
               bpgs_pkg::CMD_WAKE: begin
                  if (status.slot_ok && !status.slot_present) begin
                     op       = bpgs_pkg::OP_RD_SLOT;
                     state_in = ST_WAKE;
                  end
               end
               bpgs_pkg::CMD_REMOVE: begin
                  if (status.slot_ok && status.slot_present) op = bpgs_pkg::OP_REMOVE;
               end
               bpgs_pkg::CMD_SCHED: begin
                  if (status.count_le1) begin
                     op = bpgs_pkg::OP_SEED;
                  end else if (status.cur_zero) begin
                     op       = bpgs_pkg::OP_WALK_INIT;
                     state_in = ST_W_RD;
                  end else begin
                     op       = bpgs_pkg::OP_RD_CUR;
                     state_in = ST_UPD1;
                  end
               end
               default: ;
            endcase
         end
         ST_WAKE: begin
            op       = bpgs_pkg::OP_WAKE;
            state_in = ST_IDLE;
         end
         ST_UPD1: begin
            op       = bpgs_pkg::OP_ACC;
            state_in = ST_UPD1_WAIT;
         end
         ST_UPD1_WAIT: begin
            if (status.div_done) begin
               op       = bpgs_pkg::OP_PRED1;
               state_in = status.cur_valid ? ST_WR_CUR : ST_UPD2_WAIT;
            end
         end
         ST_UPD2_WAIT: begin
            if (status.div_done) begin
               op       = bpgs_pkg::OP_PRED2;
               state_in = ST_WR_CUR;
            end
         end
         ST_WR_CUR: begin
            op       = bpgs_pkg::OP_WR_CUR;
            state_in = ST_W_RD;
         end
         ST_W_RD: begin
            op       = bpgs_pkg::OP_RD_IDX;
            state_in = ST_W_UPD;
         end
         ST_W_UPD: begin
            op       = bpgs_pkg::OP_WAIT_UPD;
            state_in = status.idx_last ? ST_G_INIT : ST_W_RD;
         end
         ST_G_INIT: begin
            op       = bpgs_pkg::OP_G_INIT;
            state_in = ST_G_RD;
         end
         ST_G_RD: begin
            op       = bpgs_pkg::OP_RD_IDX;
            state_in = ST_G_DIV1;
         end
         ST_G_DIV1: begin
            if (status.idx_valid) begin
               op       = bpgs_pkg::OP_DIV1;
               state_in = ST_G_DIV1_WAIT;
            end else begin
               op       = bpgs_pkg::OP_IDX_INC;
               state_in = status.idx_last ? ST_F_RUN : ST_G_RD;
            end
         end
         ST_G_DIV1_WAIT: begin
            if (status.div_done) begin
               op       = bpgs_pkg::OP_DIV2;
               state_in = ST_G_DIV2_WAIT;
            end
         end
         ST_G_DIV2_WAIT: begin
            if (status.div_done) begin
               op       = bpgs_pkg::OP_Q2;
               state_in = ST_G_M0;
            end
         end
         ST_G_M0: begin
            op       = bpgs_pkg::OP_M0;
            state_in = ST_G_M1;
         end
         ST_G_M1: begin
            op       = bpgs_pkg::OP_M1;
            state_in = ST_G_M2;
         end
         ST_G_M2: begin
            op       = bpgs_pkg::OP_M2;
            state_in = ST_G_CMP;
         end
         ST_G_CMP: begin
            op       = bpgs_pkg::OP_G_CMP;
            state_in = status.idx_last ? ST_F_RUN : ST_G_RD;
         end
         ST_F_RUN: begin
            op       = bpgs_pkg::OP_F_RUN;
            state_in = ST_F_FIN;
         end
         ST_F_FIN: begin
            op       = bpgs_pkg::OP_F_FIN;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- design/burst_prediction_goodness_scheduler.sv -----
// ----------------------------------------------------------------------------
// Burst prediction goodness scheduler
// Task table with exponential burst prediction and goodness-based selection.
// ----------------------------------------------------------------------------
// Usage. An item is a command (add, wake, remove or schedule) with a task
// slot and a time stamp. It is accepted at a rising edge where start is high
// and busy is low. Add, wake and remove give no result. Schedule gives one
// result: rsp_valid is high for exactly one cycle with the chosen slot on
// rsp_next_task. The receiver cannot stall, so the result is taken then.
//
// Timing. Add, remove and an ignored command end in decode; a wake that
// takes effect reads the slot and then writes it. A schedule with only the
// seed task present returns its result from decode. Otherwise the running
// task's prediction goes once through the divide-by-three unit, twice for a
// removed task, the wait walk reads and updates each slot, and the goodness
// walk takes two divider passes, a multiply and a compare for each present
// slot and skips each absent one. Divider width DW is 64, or TIME_BITS+2
// when that is larger. All of this is set by the single shared serial
// divider and the task tables, each with one read and one write port.
//
// Reset. After reset a clearing pass zeroes the task table, one slot a
// cycle, from slot 0 to the last; busy is high until it ends. Only the
// seed slot 0 is present afterwards.
// ----------------------------------------------------------------------------
module burst_prediction_goodness_scheduler #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_cmd,
   input  logic [3:0]           req_task_slot,
   input  logic [TIME_BITS-1:0] req_now,
   output logic                 rsp_valid,
   output logic [3:0]           rsp_next_task
);

   // The divider must hold both the 64-bit goodness operands and the
   // prediction numerator 2*burst+pred, which is two bits wider than time.
   localparam int DW = (TIME_BITS + 2 > bpgs_pkg::GOOD_BITS) ?
                       TIME_BITS + 2 : bpgs_pkg::GOOD_BITS;

   bpgs_pkg::op_type     op;
   bpgs_pkg::status_type status;

   // The controller issues one datapath operation per cycle.
   bpgs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   // The datapath holds the task table and does all arithmetic.
   bpgs_datapath #(
      .NUM_SLOTS (NUM_SLOTS),
      .TIME_BITS (TIME_BITS),
      .DW        (DW)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .op            (op),
      .req_cmd       (req_cmd),
      .req_task_slot (req_task_slot),
      .req_now       (req_now),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_next_task (rsp_next_task)
   );

endmodule

// ----- design/bpgs_checker.sv -----
// ----------------------------------------------------------------------------
// Scheduler port checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module bpgs_checker #(
   parameter int NUM_SLOTS = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [3:0] rsp_next_task
);

   // An accepted item always occupies the block for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // A result is a single-cycle strobe.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result appears only once the block is idle again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // The clearing pass follows reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("block idle right after reset");

   // The chosen slot exists.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_next_task) < NUM_SLOTS))
      else $error("result slot out of range");

endmodule

bind burst_prediction_goodness_scheduler bpgs_checker #(
   .NUM_SLOTS (NUM_SLOTS)
) u_bpgs_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_next_task (rsp_next_task)
);
